// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ECPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ecpa same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ECPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ecpa next-cycle check failed");

`endif

// ===== src/ecpa_pkg.sv =====
// Shared types, constants and command structures for the EC point unit.
package ecpa_pkg;

    localparam int FIELD_WIDTH  = 64;
    localparam int SCALAR_WIDTH = 64;
    localparam int IO_W         = 64;
    localparam int FIDX_W       = $clog2(FIELD_WIDTH);
    localparam int SIDX_W       = (SCALAR_WIDTH > 1) ? $clog2(SCALAR_WIDTH) : 1;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 2'd1;

    // Item operation codes
    localparam logic [1:0] OPN_ADD = 2'd0;
    localparam logic [1:0] OPN_SUB = 2'd1;
    localparam logic [1:0] OPN_MUL = 2'd2;

    typedef logic [FIELD_WIDTH-1:0] t_field;

    // Datapath register file entries
    typedef enum logic [3:0] {
        R_QX, R_QY, R_SX, R_SY, R_AX, R_AY, R_BX, R_BY,
        R_RX, R_RY, R_A, R_NUM, R_DEN, R_K, R_INV, R_T
    } t_reg;

    // Raw values that can be reduced modulo p
    typedef enum logic [2:0] {
        RAW_A, RAW_X1, RAW_Y1, RAW_X2, RAW_Y2
    } t_raw;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_NEG, OP_MOV, OP_CONST0, OP_CONST1,
        OP_CMP, OP_MUL, OP_RED, OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic              valid;
        t_dp_op            op;
        t_reg              ra;
        t_reg              rb;
        t_reg              rd;
        t_raw              raw;
        logic              zero;
        logic [FIDX_W-1:0] eidx;
        logic [SIDX_W-1:0] sidx;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic eq;
        logic ebit;
        logic sbit;
    } t_status;

    typedef enum logic [1:0] {
        DP_IDLE, DP_EXEC, DP_MUL, DP_RED
    } t_dp_state;

    typedef enum logic [1:0] {
        LD_INPUT, LD_DOUBLE, LD_ADDQ
    } t_ldsel;

    typedef enum logic [1:0] {
        PH_SINGLE, PH_DBL, PH_ADD
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE, S_RED_A, S_RED_X1, S_RED_Y1, S_RED_X2, S_RED_Y2,
        S_CLR_X, S_CLR_Y, S_DISPATCH, S_NEG,
        S_LA_X, S_LA_Y, S_LB_X, S_LB_Y,
        S_P_START, S_P_CPX, S_P_CPY, S_P_CMPX, S_P_CMPY,
        S_P_SQ, S_P_T2, S_P_T3, S_P_TA, S_P_DEN2,
        S_P_NUMS, S_P_DENS,
        S_P_INV0, S_P_ISQ, S_P_IMUL,
        S_P_K, S_P_KK, S_P_X1, S_P_X2, S_P_Y1, S_P_Y2, S_P_Y3, S_P_Y4,
        S_P_RET, S_NEXT, S_OUT_LD, S_OUT
    } t_state;

endpackage

// ===== src/ecpa_if.sv =====
// Handshake channel interfaces: input items, results and configuration writes.
interface ecpa_item_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [ecpa_pkg::IO_W-1:0]      first_x;
    logic [ecpa_pkg::IO_W-1:0]      first_y;
    logic                           first_infinite;
    logic [ecpa_pkg::IO_W-1:0]      second_x;
    logic [ecpa_pkg::IO_W-1:0]      second_y;
    logic                           second_infinite;
    logic [ecpa_pkg::IO_W-1:0]      scalar;

    modport source (output valid, operation, first_x, first_y, first_infinite,
                    second_x, second_y, second_infinite, scalar, input ready);
    modport sink   (input valid, operation, first_x, first_y, first_infinite,
                    second_x, second_y, second_infinite, scalar, output ready);
endinterface

interface ecpa_result_if;
    logic                      valid;
    logic                      ready;
    logic [ecpa_pkg::IO_W-1:0] result_x;
    logic [ecpa_pkg::IO_W-1:0] result_y;
    logic                      result_infinite;

    modport source (output valid, result_x, result_y, result_infinite, input ready);
    modport sink   (input valid, result_x, result_y, result_infinite, output ready);
endinterface

interface ecpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ecpa_pkg::CFG_IDX_W-1:0] index;
    logic [ecpa_pkg::IO_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ecc_point_add_scalar_mult.sv =====
// Top level: affine elliptic-curve point add/subtract and scalar multiply unit.
// One item at a time. Each field multiply is bit-serial, one bit a cycle; a point
// addition is dominated by the Fermat inversion of up to 2*64 multiplies, and a
// scalar multiply performs up to 2*64 point operations.
// Synchronous active-low reset clears control, sets modulus to 2 and curve_a to 1.
module ecc_point_add_scalar_mult (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ecpa_item_if.sink    i_item,
    ecpa_result_if.source o_result,
    ecpa_cfg_if.sink     i_cfg
);

    ecpa_pkg::t_cmd    cmd;
    ecpa_pkg::t_status st;
    logic              in_ready;
    logic              in_accept;

    assign i_item.ready = in_ready;
    assign in_accept    = i_item.valid && in_ready;
    assign i_cfg.ready  = 1'b1;

    ecpa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .o_in_ready   (in_ready),
        .i_operation  (i_item.operation),
        .i_first_inf  (i_item.first_infinite),
        .i_second_inf (i_item.second_infinite),
        .o_out_valid  (o_result.valid),
        .i_out_ready  (o_result.ready),
        .o_result_inf (o_result.result_infinite),
        .o_cmd        (cmd),
        .i_st         (st)
    );

    ecpa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_in_accept (in_accept),
        .i_first_x   (i_item.first_x),
        .i_first_y   (i_item.first_y),
        .i_second_x  (i_item.second_x),
        .i_second_y  (i_item.second_y),
        .i_scalar    (i_item.scalar),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_result_x  (o_result.result_x),
        .o_result_y  (o_result.result_y)
    );

endmodule

// ===== src/ecpa_dpath.sv =====
// Field datapath: register file, bit-serial modular multiplier and reducer.
module ecpa_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ecpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ecpa_pkg::IO_W-1:0]      i_cfg_data,
    input  logic                           i_in_accept,
    input  logic [ecpa_pkg::IO_W-1:0]      i_first_x,
    input  logic [ecpa_pkg::IO_W-1:0]      i_first_y,
    input  logic [ecpa_pkg::IO_W-1:0]      i_second_x,
    input  logic [ecpa_pkg::IO_W-1:0]      i_second_y,
    input  logic [ecpa_pkg::IO_W-1:0]      i_scalar,
    input  ecpa_pkg::t_cmd                 i_cmd,
    output ecpa_pkg::t_status              o_st,
    output logic [ecpa_pkg::IO_W-1:0]      o_result_x,
    output logic [ecpa_pkg::IO_W-1:0]      o_result_y
);

    localparam int FW = ecpa_pkg::FIELD_WIDTH;

    ecpa_pkg::t_field r_mem [16];

    ecpa_pkg::t_field r_modulus, r_curve_a;
    ecpa_pkg::t_field r_raw_x1, r_raw_y1, r_raw_x2, r_raw_y2;
    logic [ecpa_pkg::SCALAR_WIDTH-1:0] r_scalar;

    ecpa_pkg::t_dp_state r_state;
    ecpa_pkg::t_cmd      r_cmd;
    ecpa_pkg::t_field    r_rda, r_rdb;
    ecpa_pkg::t_field    r_acc, r_ma, r_mb;
    logic [ecpa_pkg::FIDX_W-1:0] r_cnt;
    logic                r_done, r_eq;
    ecpa_pkg::t_field    r_res_x, r_res_y;

    ecpa_pkg::t_field me, expo, one_m, raw_sel;
    ecpa_pkg::t_field mul_dbl, mul_next, red_next;
    logic [FW:0]      red_shift;
    logic             w_en;
    ecpa_pkg::t_reg   w_addr;
    ecpa_pkg::t_field w_data;

    function automatic ecpa_pkg::t_field fadd(input ecpa_pkg::t_field a,
                                              input ecpa_pkg::t_field b,
                                              input ecpa_pkg::t_field m);
        logic [FW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[FW-1:0];
    endfunction

    function automatic ecpa_pkg::t_field fsub(input ecpa_pkg::t_field a,
                                              input ecpa_pkg::t_field b,
                                              input ecpa_pkg::t_field m);
        ecpa_pkg::t_field d;
        d = a - b;
        if (a < b) d = d + m;
        return d;
    endfunction

    // Effective modulus: a modulus below two behaves as one (all values zero)
    assign me    = (r_modulus < FW'(2)) ? FW'(1) : r_modulus;
    assign expo  = me - FW'(2);
    assign one_m = (me == FW'(1)) ? '0 : FW'(1);

    // Select the raw value to reduce
    always_comb begin
        case (r_cmd.raw)
            ecpa_pkg::RAW_A:  raw_sel = r_curve_a;
            ecpa_pkg::RAW_X1: raw_sel = r_raw_x1;
            ecpa_pkg::RAW_Y1: raw_sel = r_raw_y1;
            ecpa_pkg::RAW_X2: raw_sel = r_raw_x2;
            ecpa_pkg::RAW_Y2: raw_sel = r_raw_y2;
            default:          raw_sel = '0;
        endcase
    end

    // One double-and-add step of the multiplier, one shift-subtract of the reducer
    assign mul_dbl   = fadd(r_acc, r_acc, me);
    assign mul_next  = r_mb[r_cnt] ? fadd(mul_dbl, r_ma, me) : mul_dbl;
    assign red_shift = {r_acc, r_mb[r_cnt]};
    always_comb begin
        if (red_shift >= {1'b0, me}) begin
            red_next = FW'(red_shift - {1'b0, me});
        end else begin
            red_next = red_shift[FW-1:0];
        end
    end

    // Register file write port
    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cmd.rd;
        w_data = '0;
        case (r_state)
            ecpa_pkg::DP_EXEC: begin
                case (r_cmd.op)
                    ecpa_pkg::OP_ADD:    begin w_en = 1'b1; w_data = fadd(r_rda, r_rdb, me); end
                    ecpa_pkg::OP_SUB:    begin w_en = 1'b1; w_data = fsub(r_rda, r_rdb, me); end
                    ecpa_pkg::OP_NEG:    begin w_en = 1'b1; w_data = fsub('0, r_rda, me); end
                    ecpa_pkg::OP_MOV:    begin w_en = 1'b1; w_data = r_rda; end
                    ecpa_pkg::OP_CONST0: begin w_en = 1'b1; w_data = '0; end
                    ecpa_pkg::OP_CONST1: begin w_en = 1'b1; w_data = one_m; end
                    default:             w_en = 1'b0;
                endcase
            end
            ecpa_pkg::DP_MUL: begin
                w_en   = (r_cnt == '0);
                w_data = mul_next;
            end
            ecpa_pkg::DP_RED: begin
                w_en   = (r_cnt == '0);
                w_data = red_next;
            end
            default: w_en = 1'b0;
        endcase
    end

    // Register file: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        if (i_cmd.valid) begin
            r_rda <= r_mem[i_cmd.ra];
            r_rdb <= r_mem[i_cmd.rb];
        end
    end

    // Capture item operands on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_raw_x1 <= i_first_x[FW-1:0];
            r_raw_y1 <= i_first_y[FW-1:0];
            r_raw_x2 <= i_second_x[FW-1:0];
            r_raw_y2 <= i_second_y[FW-1:0];
            r_scalar <= i_scalar[ecpa_pkg::SCALAR_WIDTH-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= FW'(2);
            r_curve_a <= FW'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == ecpa_pkg::REG_MODULUS) r_modulus <= i_cfg_data[FW-1:0];
            if (i_cfg_index == ecpa_pkg::REG_CURVE_A) r_curve_a <= i_cfg_data[FW-1:0];
        end
    end

    // Operation sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecpa_pkg::DP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ecpa_pkg::DP_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= ecpa_pkg::DP_EXEC;
                    end
                end
                ecpa_pkg::DP_EXEC: begin
                    r_acc <= '0;
                    r_ma  <= r_rda;
                    r_cnt <= ecpa_pkg::FIDX_W'(FW - 1);
                    case (r_cmd.op)
                        ecpa_pkg::OP_MUL: begin
                            r_mb    <= r_rdb;
                            r_state <= ecpa_pkg::DP_MUL;
                        end
                        ecpa_pkg::OP_RED: begin
                            r_mb    <= raw_sel;
                            r_state <= ecpa_pkg::DP_RED;
                        end
                        ecpa_pkg::OP_CMP: begin
                            r_eq    <= (r_rda == r_rdb);
                            r_done  <= 1'b1;
                            r_state <= ecpa_pkg::DP_IDLE;
                        end
                        ecpa_pkg::OP_OUT: begin
                            r_res_x <= r_cmd.zero ? '0 : r_rda;
                            r_res_y <= r_cmd.zero ? '0 : r_rdb;
                            r_done  <= 1'b1;
                            r_state <= ecpa_pkg::DP_IDLE;
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= ecpa_pkg::DP_IDLE;
                        end
                    endcase
                end
                ecpa_pkg::DP_MUL, ecpa_pkg::DP_RED: begin
                    r_acc <= (r_state == ecpa_pkg::DP_MUL) ? mul_next : red_next;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= ecpa_pkg::DP_IDLE;
                    end
                end
                default: r_state <= ecpa_pkg::DP_IDLE;
            endcase
        end
    end

    assign o_st.done = r_done;
    assign o_st.eq   = r_eq;
    assign o_st.ebit = expo[i_cmd.eidx];
    assign o_st.sbit = r_scalar[i_cmd.sidx];

    assign o_result_x = ecpa_pkg::IO_W'(r_res_x);
    assign o_result_y = ecpa_pkg::IO_W'(r_res_y);

endmodule

// ===== src/ecpa_ctrl.sv =====
// Controller: sequences reduction, point addition, inversion and double-and-add.
module ecpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic              i_first_inf,
    input  logic              i_second_inf,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_result_inf,
    output ecpa_pkg::t_cmd    o_cmd,
    input  ecpa_pkg::t_status i_st
);

    ecpa_pkg::t_state r_state, n_state;
    logic             r_sent, n_sent;
    logic [1:0]       r_op, n_op;
    logic             r_inf1, n_inf1, r_inf2, n_inf2;
    logic             r_ainf, n_ainf, r_binf, n_binf, r_rinf, n_rinf;
    ecpa_pkg::t_ldsel r_ldsel, n_ldsel;
    ecpa_pkg::t_phase r_phase, n_phase;
    logic [ecpa_pkg::FIDX_W-1:0] r_eidx, n_eidx;
    logic [ecpa_pkg::SIDX_W-1:0] r_sidx, n_sidx;

    logic             c_has;
    ecpa_pkg::t_dp_op c_op;
    ecpa_pkg::t_reg   c_ra, c_rb, c_rd;
    ecpa_pkg::t_raw   c_raw;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecpa_pkg::S_IDLE;
            r_sent  <= 1'b0;
            r_op    <= '0;
            r_inf1  <= 1'b0;
            r_inf2  <= 1'b0;
            r_ainf  <= 1'b0;
            r_binf  <= 1'b0;
            r_rinf  <= 1'b0;
            r_ldsel <= ecpa_pkg::LD_INPUT;
            r_phase <= ecpa_pkg::PH_SINGLE;
            r_eidx  <= '0;
            r_sidx  <= '0;
        end else begin
            r_state <= n_state;
            r_sent  <= n_sent;
            r_op    <= n_op;
            r_inf1  <= n_inf1;
            r_inf2  <= n_inf2;
            r_ainf  <= n_ainf;
            r_binf  <= n_binf;
            r_rinf  <= n_rinf;
            r_ldsel <= n_ldsel;
            r_phase <= n_phase;
            r_eidx  <= n_eidx;
            r_sidx  <= n_sidx;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_sent  = r_sent;
        n_op    = r_op;
        n_inf1  = r_inf1;
        n_inf2  = r_inf2;
        n_ainf  = r_ainf;
        n_binf  = r_binf;
        n_rinf  = r_rinf;
        n_ldsel = r_ldsel;
        n_phase = r_phase;
        n_eidx  = r_eidx;
        n_sidx  = r_sidx;
        c_has   = 1'b0;
        c_op    = ecpa_pkg::OP_MOV;
        c_ra    = ecpa_pkg::R_T;
        c_rb    = ecpa_pkg::R_T;
        c_rd    = ecpa_pkg::R_T;
        c_raw   = ecpa_pkg::RAW_A;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        case (r_state)
            ecpa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_inf1  = i_first_inf;
                    n_inf2  = i_second_inf;
                    n_state = ecpa_pkg::S_RED_A;
                end
            end
            // Reduce the coefficient and the coordinates modulo p
            ecpa_pkg::S_RED_A: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_RED; c_raw = ecpa_pkg::RAW_A;
                c_rd  = ecpa_pkg::R_A;
                if (i_st.done) n_state = ecpa_pkg::S_RED_X1;
            end
            ecpa_pkg::S_RED_X1: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_RED; c_raw = ecpa_pkg::RAW_X1;
                c_rd  = ecpa_pkg::R_QX;
                if (i_st.done) n_state = ecpa_pkg::S_RED_Y1;
            end
            ecpa_pkg::S_RED_Y1: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_RED; c_raw = ecpa_pkg::RAW_Y1;
                c_rd  = ecpa_pkg::R_QY;
                if (i_st.done) n_state = ecpa_pkg::S_RED_X2;
            end
            ecpa_pkg::S_RED_X2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_RED; c_raw = ecpa_pkg::RAW_X2;
                c_rd  = ecpa_pkg::R_SX;
                if (i_st.done) n_state = ecpa_pkg::S_RED_Y2;
            end
            ecpa_pkg::S_RED_Y2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_RED; c_raw = ecpa_pkg::RAW_Y2;
                c_rd  = ecpa_pkg::R_SY;
                if (i_st.done) n_state = ecpa_pkg::S_CLR_X;
            end
            ecpa_pkg::S_CLR_X: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_CONST0; c_rd = ecpa_pkg::R_RX;
                if (i_st.done) n_state = ecpa_pkg::S_CLR_Y;
            end
            ecpa_pkg::S_CLR_Y: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_CONST0; c_rd = ecpa_pkg::R_RY;
                if (i_st.done) n_state = ecpa_pkg::S_DISPATCH;
            end
            ecpa_pkg::S_DISPATCH: begin
                n_ldsel = ecpa_pkg::LD_INPUT;
                n_phase = ecpa_pkg::PH_SINGLE;
                n_ainf  = r_inf1;
                n_binf  = r_inf2;
                if (r_op == ecpa_pkg::OPN_ADD) begin
                    n_state = ecpa_pkg::S_LA_X;
                end else if (r_op == ecpa_pkg::OPN_SUB) begin
                    n_state = ecpa_pkg::S_NEG;
                end else if (r_op == ecpa_pkg::OPN_MUL) begin
                    n_rinf  = 1'b1;
                    n_sidx  = ecpa_pkg::SIDX_W'(ecpa_pkg::SCALAR_WIDTH - 1);
                    n_ldsel = ecpa_pkg::LD_DOUBLE;
                    n_phase = ecpa_pkg::PH_DBL;
                    n_ainf  = 1'b1;
                    n_binf  = 1'b1;
                    n_state = ecpa_pkg::S_LA_X;
                end else begin
                    n_rinf  = 1'b1;
                    n_state = ecpa_pkg::S_OUT_LD;
                end
            end
            // Negate the second y for subtraction
            ecpa_pkg::S_NEG: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_NEG;
                c_ra  = ecpa_pkg::R_SY; c_rd = ecpa_pkg::R_SY;
                if (i_st.done) n_state = ecpa_pkg::S_LA_X;
            end
            // Load the operands of one point addition
            ecpa_pkg::S_LA_X: begin
                c_has = 1'b1;
                c_ra  = (r_ldsel == ecpa_pkg::LD_INPUT) ? ecpa_pkg::R_QX : ecpa_pkg::R_RX;
                c_rd  = ecpa_pkg::R_AX;
                if (i_st.done) n_state = ecpa_pkg::S_LA_Y;
            end
            ecpa_pkg::S_LA_Y: begin
                c_has = 1'b1;
                c_ra  = (r_ldsel == ecpa_pkg::LD_INPUT) ? ecpa_pkg::R_QY : ecpa_pkg::R_RY;
                c_rd  = ecpa_pkg::R_AY;
                if (i_st.done) n_state = ecpa_pkg::S_LB_X;
            end
            ecpa_pkg::S_LB_X: begin
                c_has = 1'b1;
                case (r_ldsel)
                    ecpa_pkg::LD_INPUT:  c_ra = ecpa_pkg::R_SX;
                    ecpa_pkg::LD_DOUBLE: c_ra = ecpa_pkg::R_RX;
                    default:             c_ra = ecpa_pkg::R_QX;
                endcase
                c_rd = ecpa_pkg::R_BX;
                if (i_st.done) n_state = ecpa_pkg::S_LB_Y;
            end
            ecpa_pkg::S_LB_Y: begin
                c_has = 1'b1;
                case (r_ldsel)
                    ecpa_pkg::LD_INPUT:  c_ra = ecpa_pkg::R_SY;
                    ecpa_pkg::LD_DOUBLE: c_ra = ecpa_pkg::R_RY;
                    default:             c_ra = ecpa_pkg::R_QY;
                endcase
                c_rd = ecpa_pkg::R_BY;
                if (i_st.done) n_state = ecpa_pkg::S_P_START;
            end
            // Point addition: infinity cases first
            ecpa_pkg::S_P_START: begin
                if (r_binf) begin
                    n_rinf  = r_ainf;
                    n_state = ecpa_pkg::S_P_CPX;
                end else if (r_ainf) begin
                    n_rinf  = 1'b0;
                    n_state = ecpa_pkg::S_P_CPX;
                end else begin
                    n_state = ecpa_pkg::S_P_CMPX;
                end
            end
            ecpa_pkg::S_P_CPX: begin
                c_has = 1'b1;
                c_ra  = r_binf ? ecpa_pkg::R_AX : ecpa_pkg::R_BX;
                c_rd  = ecpa_pkg::R_RX;
                if (i_st.done) n_state = ecpa_pkg::S_P_CPY;
            end
            ecpa_pkg::S_P_CPY: begin
                c_has = 1'b1;
                c_ra  = r_binf ? ecpa_pkg::R_AY : ecpa_pkg::R_BY;
                c_rd  = ecpa_pkg::R_RY;
                if (i_st.done) n_state = ecpa_pkg::S_P_RET;
            end
            ecpa_pkg::S_P_CMPX: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_CMP;
                c_ra  = ecpa_pkg::R_AX; c_rb = ecpa_pkg::R_BX;
                if (i_st.done) n_state = i_st.eq ? ecpa_pkg::S_P_CMPY : ecpa_pkg::S_P_NUMS;
            end
            ecpa_pkg::S_P_CMPY: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_CMP;
                c_ra  = ecpa_pkg::R_AY; c_rb = ecpa_pkg::R_BY;
                if (i_st.done) begin
                    if (i_st.eq) begin
                        n_state = ecpa_pkg::S_P_SQ;
                    end else begin
                        n_rinf  = 1'b1;
                        n_state = ecpa_pkg::S_P_RET;
                    end
                end
            end
            // Doubling slope: (3x^2 + a) / 2y
            ecpa_pkg::S_P_SQ: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_AX; c_rb = ecpa_pkg::R_AX; c_rd = ecpa_pkg::R_NUM;
                if (i_st.done) n_state = ecpa_pkg::S_P_T2;
            end
            ecpa_pkg::S_P_T2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_ADD;
                c_ra  = ecpa_pkg::R_NUM; c_rb = ecpa_pkg::R_NUM; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_T3;
            end
            ecpa_pkg::S_P_T3: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_ADD;
                c_ra  = ecpa_pkg::R_T; c_rb = ecpa_pkg::R_NUM; c_rd = ecpa_pkg::R_NUM;
                if (i_st.done) n_state = ecpa_pkg::S_P_TA;
            end
            ecpa_pkg::S_P_TA: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_ADD;
                c_ra  = ecpa_pkg::R_NUM; c_rb = ecpa_pkg::R_A; c_rd = ecpa_pkg::R_NUM;
                if (i_st.done) n_state = ecpa_pkg::S_P_DEN2;
            end
            ecpa_pkg::S_P_DEN2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_ADD;
                c_ra  = ecpa_pkg::R_AY; c_rb = ecpa_pkg::R_AY; c_rd = ecpa_pkg::R_DEN;
                if (i_st.done) n_state = ecpa_pkg::S_P_INV0;
            end
            // Chord slope: (y2 - y1) / (x2 - x1)
            ecpa_pkg::S_P_NUMS: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_SUB;
                c_ra  = ecpa_pkg::R_BY; c_rb = ecpa_pkg::R_AY; c_rd = ecpa_pkg::R_NUM;
                if (i_st.done) n_state = ecpa_pkg::S_P_DENS;
            end
            ecpa_pkg::S_P_DENS: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_SUB;
                c_ra  = ecpa_pkg::R_BX; c_rb = ecpa_pkg::R_AX; c_rd = ecpa_pkg::R_DEN;
                if (i_st.done) n_state = ecpa_pkg::S_P_INV0;
            end
            // Fermat inverse: square and multiply over the bits of p-2
            ecpa_pkg::S_P_INV0: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_CONST1; c_rd = ecpa_pkg::R_INV;
                if (i_st.done) begin
                    n_eidx  = ecpa_pkg::FIDX_W'(ecpa_pkg::FIELD_WIDTH - 1);
                    n_state = ecpa_pkg::S_P_ISQ;
                end
            end
            ecpa_pkg::S_P_ISQ: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_INV; c_rb = ecpa_pkg::R_INV; c_rd = ecpa_pkg::R_INV;
                if (i_st.done) begin
                    if (i_st.ebit) begin
                        n_state = ecpa_pkg::S_P_IMUL;
                    end else if (r_eidx == '0) begin
                        n_state = ecpa_pkg::S_P_K;
                    end else begin
                        n_eidx  = r_eidx - 1'b1;
                    end
                end
            end
            ecpa_pkg::S_P_IMUL: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_INV; c_rb = ecpa_pkg::R_DEN; c_rd = ecpa_pkg::R_INV;
                if (i_st.done) begin
                    if (r_eidx == '0) begin
                        n_state = ecpa_pkg::S_P_K;
                    end else begin
                        n_eidx  = r_eidx - 1'b1;
                        n_state = ecpa_pkg::S_P_ISQ;
                    end
                end
            end
            // New point from the slope
            ecpa_pkg::S_P_K: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_NUM; c_rb = ecpa_pkg::R_INV; c_rd = ecpa_pkg::R_K;
                if (i_st.done) n_state = ecpa_pkg::S_P_KK;
            end
            ecpa_pkg::S_P_KK: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_K; c_rb = ecpa_pkg::R_K; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_X1;
            end
            ecpa_pkg::S_P_X1: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_SUB;
                c_ra  = ecpa_pkg::R_T; c_rb = ecpa_pkg::R_AX; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_X2;
            end
            ecpa_pkg::S_P_X2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_SUB;
                c_ra  = ecpa_pkg::R_T; c_rb = ecpa_pkg::R_BX; c_rd = ecpa_pkg::R_RX;
                if (i_st.done) n_state = ecpa_pkg::S_P_Y1;
            end
            ecpa_pkg::S_P_Y1: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_SUB;
                c_ra  = ecpa_pkg::R_RX; c_rb = ecpa_pkg::R_AX; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_Y2;
            end
            ecpa_pkg::S_P_Y2: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_MUL;
                c_ra  = ecpa_pkg::R_K; c_rb = ecpa_pkg::R_T; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_Y3;
            end
            ecpa_pkg::S_P_Y3: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_ADD;
                c_ra  = ecpa_pkg::R_T; c_rb = ecpa_pkg::R_AY; c_rd = ecpa_pkg::R_T;
                if (i_st.done) n_state = ecpa_pkg::S_P_Y4;
            end
            ecpa_pkg::S_P_Y4: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_NEG;
                c_ra  = ecpa_pkg::R_T; c_rd = ecpa_pkg::R_RY;
                if (i_st.done) begin
                    n_rinf  = 1'b0;
                    n_state = ecpa_pkg::S_P_RET;
                end
            end
            // Return from point addition
            ecpa_pkg::S_P_RET: begin
                case (r_phase)
                    ecpa_pkg::PH_DBL: begin
                        if (i_st.sbit) begin
                            n_ldsel = ecpa_pkg::LD_ADDQ;
                            n_phase = ecpa_pkg::PH_ADD;
                            n_ainf  = r_rinf;
                            n_binf  = r_inf1;
                            n_state = ecpa_pkg::S_LA_X;
                        end else begin
                            n_state = ecpa_pkg::S_NEXT;
                        end
                    end
                    ecpa_pkg::PH_ADD: n_state = ecpa_pkg::S_NEXT;
                    default:          n_state = ecpa_pkg::S_OUT_LD;
                endcase
            end
            // Advance to the next scalar bit
            ecpa_pkg::S_NEXT: begin
                if (r_sidx == '0) begin
                    n_state = ecpa_pkg::S_OUT_LD;
                end else begin
                    n_sidx  = r_sidx - 1'b1;
                    n_ldsel = ecpa_pkg::LD_DOUBLE;
                    n_phase = ecpa_pkg::PH_DBL;
                    n_ainf  = r_rinf;
                    n_binf  = r_rinf;
                    n_state = ecpa_pkg::S_LA_X;
                end
            end
            ecpa_pkg::S_OUT_LD: begin
                c_has = 1'b1; c_op = ecpa_pkg::OP_OUT;
                c_ra  = ecpa_pkg::R_RX; c_rb = ecpa_pkg::R_RY;
                if (i_st.done) n_state = ecpa_pkg::S_OUT;
            end
            ecpa_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ecpa_pkg::S_IDLE;
            end
            default: n_state = ecpa_pkg::S_IDLE;
        endcase

        // Issue each command once, then wait for done
        if (c_has && !r_sent) n_sent = 1'b1;
        if (i_st.done)        n_sent = 1'b0;
    end

    assign o_cmd.valid = c_has && !r_sent;
    assign o_cmd.op    = c_op;
    assign o_cmd.ra    = c_ra;
    assign o_cmd.rb    = c_rb;
    assign o_cmd.rd    = c_rd;
    assign o_cmd.raw   = c_raw;
    assign o_cmd.zero  = r_rinf;
    assign o_cmd.eidx  = r_eidx;
    assign o_cmd.sidx  = r_sidx;

    assign o_result_inf = r_rinf;

endmodule

// ===== src/ecpa_checker.sv =====
// Port-level checker for the EC point unit, bound to the top level.
`include "assert_macros.svh"

module ecpa_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [ecpa_pkg::IO_W-1:0] i_result_x,
    input logic [ecpa_pkg::IO_W-1:0] i_result_y,
    input logic                      i_result_inf
);

    // An infinite result shows zero coordinates
    `ECPA_ASSERT_NOW(a_inf_zero, i_out_valid && i_result_inf, (i_result_x == '0) && (i_result_y == '0))

    // One item at a time: no input transfer while a result is offered
    `ECPA_ASSERT_NOW(a_one_at_a_time, i_out_valid, !i_in_ready)

    // A result never appears the cycle after an input transfer
    `ECPA_ASSERT_NEXT(a_no_instant_result, i_in_valid && i_in_ready, !i_out_valid)

    // A stalled result holds its value
    `ECPA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_result_x) && $stable(i_result_y))

endmodule

bind ecc_point_add_scalar_mult ecpa_checker u_ecpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_result_x   (o_result.result_x),
    .i_result_y   (o_result.result_y),
    .i_result_inf (o_result.result_infinite)
);
